@@ src/mrws_pkg.sv @@
`default_nettype none
package mrws_pkg;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PAIR,
		ST_RD,
		ST_WAIT,
		ST_CHK,
		ST_NEXT,
		ST_DELAY,
		ST_FIN,
		ST_OUT
	} state_t;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_MARGIN = 2'd1;

	typedef struct packed {
		logic pair_start;
		logic rd_issue;
		logic inner_next;
		logic add_delay;
		logic mark_clean;
		logic pair_advance;
		logic solve_init;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last_pair_idx;
		logic pair_is_clean;
		logic empty_pair;
		logic hit;
		logic scan_done;
		logic cap_hit;
		logic all_clean;
	} sts_t;

	function automatic logic [1:0] pair_a(input logic [1:0] p);
		case (p)
			2'd0: pair_a = 2'd0;
			2'd1: pair_a = 2'd1;
			default: pair_a = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] pair_b(input logic [1:0] p);
		case (p)
			2'd0: pair_b = 2'd1;
			default: pair_b = 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] clr_a(input logic [1:0] p);
		case (p)
			2'd0: clr_a = 2'd2;
			default: clr_a = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] clr_b(input logic [1:0] p);
		case (p)
			2'd1: clr_b = 2'd2;
			default: clr_b = 2'd1;
		endcase
	endfunction

endpackage
`default_nettype wire

@@ src/multi_robot_wait_scheduler_core.sv @@
// Multi-robot start-delay scheduler.
// Input channel (in_valid/in_stall): one path sample per transaction, paths
// 0, 1, 2 in order; samples are taken back to back while loading. The
// transaction with last_sample on path 2 starts the solve; in_stall is high
// from then until the result transaction completes.
// Solve: each pair check scans the sample pairs of two paths until the first
// hit, reading each sample pair through the sample memory read port in states
// RD, WAIT and CHK; PAIR and NEXT come per pair, DELAY per added delay.
// Output channel (out_valid/out_stall): one transaction with the three delays
// times five and gave_up. The result holds while out_stall is high; loading
// resumes once it is taken.
// Reset: radius 256, margin 102, all path counts zero. The sample memory
// needs no clearing; only entries written in the current batch are read.
// Config writes (cfg_we/cfg_index/cfg_data) are taken any cycle, and must
// only be issued while idle.
`default_nettype none
module multi_robot_wait_scheduler_core #(
	parameter int MAX_SAMPLES = 256,
	parameter int MAX_ROUNDS  = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  path_index,
	input  wire logic [23:0] sample_x,
	input  wire logic [23:0] sample_y,
	input  wire logic [23:0] arc_length,
	input  wire logic        last_sample,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      delay_robot0,
	output logic [31:0]      delay_robot1,
	output logic [31:0]      delay_robot2,
	output logic             gave_up,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	mrws_pkg::state_t state;
	mrws_pkg::cmd_t   cmd;
	mrws_pkg::sts_t   sts;
	logic load_en, solve_go, out_taken;

	assign in_stall = (state != mrws_pkg::ST_LOAD);
	assign load_en = in_valid && !in_stall && (path_index != 2'd3);
	assign solve_go = load_en && (path_index == 2'd2) && last_sample;
	assign out_valid = (state == mrws_pkg::ST_OUT);
	assign out_taken = out_valid && !out_stall;

	mrws_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .solve_go(solve_go), .out_taken(out_taken),
		.sts(sts), .state(state), .cmd(cmd)
	);

	mrws_dp #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_ROUNDS(MAX_ROUNDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .load_en(load_en), .path_index(path_index),
		.sample_x(sample_x), .sample_y(sample_y), .arc_length(arc_length),
		.cfg_we(cfg_we), .cfg_sel(cfg_index), .cfg_data(cfg_data),
		.out_taken(out_taken), .cmd(cmd), .sts(sts),
		.delay_robot0(delay_robot0), .delay_robot1(delay_robot1),
		.delay_robot2(delay_robot2), .gave_up(gave_up)
	);

	a_stall_in_solve: assert property (@(posedge clk) disable iff (!arst_n)
		solve_go |=> in_stall) else $error("input not stalled during solve");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(delay_robot0)))
		else $error("result changed while stalled");
	a_no_out_loading: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid) else $error("result shown while loading");
endmodule
`default_nettype wire

@@ src/mrws_ctrl.sv @@
`default_nettype none
module mrws_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           solve_go,
	input  wire logic           out_taken,
	input  wire mrws_pkg::sts_t sts,
	output mrws_pkg::state_t    state,
	output mrws_pkg::cmd_t      cmd
);
	mrws_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mrws_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	assign state = state_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mrws_pkg::ST_LOAD:  if (solve_go) state_d = mrws_pkg::ST_PAIR;
			mrws_pkg::ST_PAIR: begin
				if (sts.pair_is_clean) state_d = mrws_pkg::ST_NEXT;
				else if (sts.empty_pair) state_d = mrws_pkg::ST_NEXT;
				else state_d = mrws_pkg::ST_RD;
			end
			mrws_pkg::ST_RD:    state_d = mrws_pkg::ST_WAIT;
			mrws_pkg::ST_WAIT:  state_d = mrws_pkg::ST_CHK;
			mrws_pkg::ST_CHK: begin
				if (sts.hit) state_d = sts.cap_hit ? mrws_pkg::ST_FIN : mrws_pkg::ST_DELAY;
				else if (sts.scan_done) state_d = mrws_pkg::ST_NEXT;
				else state_d = mrws_pkg::ST_RD;
			end
			mrws_pkg::ST_DELAY: state_d = mrws_pkg::ST_PAIR;
			mrws_pkg::ST_NEXT: begin
				if (sts.last_pair_idx)
					state_d = sts.all_clean ? mrws_pkg::ST_FIN : mrws_pkg::ST_PAIR;
				else state_d = mrws_pkg::ST_PAIR;
			end
			mrws_pkg::ST_FIN:   state_d = mrws_pkg::ST_OUT;
			mrws_pkg::ST_OUT:   if (out_taken) state_d = mrws_pkg::ST_LOAD;
			default:            state_d = mrws_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			mrws_pkg::ST_LOAD:  cmd.solve_init = solve_go;
			mrws_pkg::ST_PAIR:  cmd.pair_start = 1'b1;
			mrws_pkg::ST_RD:    cmd.rd_issue = 1'b1;
			mrws_pkg::ST_CHK: begin
				cmd.inner_next = !sts.hit && !sts.scan_done;
				cmd.mark_clean = !sts.hit && sts.scan_done;
				cmd.finish = sts.hit && sts.cap_hit;
			end
			mrws_pkg::ST_DELAY: cmd.add_delay = 1'b1;
			mrws_pkg::ST_NEXT:  cmd.pair_advance = 1'b1;
			mrws_pkg::ST_FIN:   cmd.out_load = 1'b1;
			default:            cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

@@ src/mrws_dp.sv @@
`default_nettype none
module mrws_dp #(
	parameter int MAX_SAMPLES = 256,
	parameter int MAX_ROUNDS  = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load_en,
	input  wire logic [1:0]       path_index,
	input  wire logic [23:0]      sample_x,
	input  wire logic [23:0]      sample_y,
	input  wire logic [23:0]      arc_length,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_sel,
	input  wire logic [15:0]      cfg_data,
	input  wire logic             out_taken,
	input  wire mrws_pkg::cmd_t   cmd,
	output mrws_pkg::sts_t        sts,
	output logic [31:0]           delay_robot0,
	output logic [31:0]           delay_robot1,
	output logic [31:0]           delay_robot2,
	output logic                  gave_up
);
	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int RW = $clog2(MAX_ROUNDS + 1);
	localparam int DEPTH = 3 * MAX_SAMPLES;
	localparam int MW = $clog2(DEPTH);

	logic [71:0] mem [DEPTH];
	logic [71:0] rd_a_q, rd_b_q;
	logic [CW-1:0] cnt_q [3];
	logic [23:0] tot_q [3];
	logic [31:0] dly_q [3];
	logic [2:0] clean_q;
	logic [RW-1:0] rnd_q;
	logic [1:0] pair_q;
	logic [CW-1:0] i_q, j_q;
	logic [15:0] rad_q, mar_q;
	logic gave_q;
	logic [31:0] out0_q, out1_q, out2_q;

	logic [1:0] pa, pb;
	logic [MW-1:0] wr_addr, addr_a, addr_b;
	logic [24:0] dx, dy;
	logic [49:0] dx2, dy2;
	logic [50:0] d2;
	logic [33:0] near;
	logic [17:0] gap;
	logic signed [34:0] ta, tb, dt;
	logic [34:0] adt;
	logic a_wins;
	logic [1:0] who, clr;
	logic [32:0] dsum;

	assign pa = mrws_pkg::pair_a(pair_q);
	assign pb = mrws_pkg::pair_b(pair_q);

	function automatic logic [MW-1:0] mk_addr(input logic [1:0] p, input logic [CW-1:0] k);
		logic [MW+1:0] t;
		t = (MW+2)'(p) * (MW+2)'(MAX_SAMPLES) + (MW+2)'(k[AW-1:0]);
		mk_addr = t[MW-1:0];
	endfunction

	assign wr_addr = mk_addr(path_index, cnt_q[path_index]);
	assign addr_a = mk_addr(pa, i_q);
	assign addr_b = mk_addr(pb, j_q);

	always_ff @(posedge clk) begin
		if (load_en && cnt_q[path_index] < CW'(MAX_SAMPLES))
			mem[wr_addr] <= {sample_x, sample_y, arc_length};
		if (cmd.rd_issue) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
		end
	end

	assign dx = {rd_a_q[71], rd_a_q[71:48]} - {rd_b_q[71], rd_b_q[71:48]};
	assign dy = {rd_a_q[47], rd_a_q[47:24]} - {rd_b_q[47], rd_b_q[47:24]};
	assign dx2 = 50'($signed(dx) * $signed(dx));
	assign dy2 = 50'($signed(dy) * $signed(dy));
	assign d2 = {1'b0, dx2} + {1'b0, dy2};
	assign near = {rad_q, 1'b0} * {rad_q, 1'b0};
	assign gap = {1'b0, rad_q, 1'b0} + {2'b0, mar_q};
	assign ta = $signed({11'b0, rd_a_q[23:0]}) + $signed({3'b0, dly_q[pa]});
	assign tb = $signed({11'b0, rd_b_q[23:0]}) + $signed({3'b0, dly_q[pb]});
	assign dt = ta - tb;
	assign adt = dt[34] ? 35'(-dt) : 35'(dt);

	assign a_wins = !(tot_q[pa] < tot_q[pb]);
	assign who = a_wins ? pa : pb;
	assign clr = a_wins ? mrws_pkg::clr_a(pair_q) : mrws_pkg::clr_b(pair_q);
	assign dsum = {1'b0, dly_q[who]} + {15'b0, gap};

	assign sts.last_pair_idx = (pair_q == 2'd2);
	assign sts.pair_is_clean = clean_q[pair_q];
	assign sts.empty_pair = (cnt_q[pa] == '0) || (cnt_q[pb] == '0);
	assign sts.hit = (d2 <= 51'(near)) && (adt <= 35'(gap));
	assign sts.scan_done = (i_q == cnt_q[pa] - 1'b1) && (j_q == cnt_q[pb] - 1'b1);
	assign sts.cap_hit = (rnd_q >= RW'(MAX_ROUNDS));
	assign sts.all_clean = &clean_q;

	function automatic logic [31:0] times5(input logic [31:0] v);
		logic [34:0] t;
		t = {3'b0, v} + {1'b0, v, 2'b0};
		times5 = (t[34:32] != 3'b0) ? 32'hFFFF_FFFF : t[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				cnt_q[k] <= '0;
				dly_q[k] <= '0;
			end
			clean_q <= '0;
			rnd_q <= '0;
			pair_q <= '0;
			i_q <= '0;
			j_q <= '0;
			rad_q <= 16'd256;
			mar_q <= 16'd102;
			gave_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_sel == mrws_pkg::REG_RADIUS) rad_q <= cfg_data;
			if (cfg_we && cfg_sel == mrws_pkg::REG_MARGIN) mar_q <= cfg_data;
			if (load_en && cnt_q[path_index] < CW'(MAX_SAMPLES))
				cnt_q[path_index] <= cnt_q[path_index] + 1'b1;
			if (cmd.solve_init) begin
				for (int k = 0; k < 3; k++) dly_q[k] <= '0;
				clean_q <= '0;
				rnd_q <= '0;
				pair_q <= '0;
				gave_q <= 1'b0;
			end
			if (cmd.pair_start) begin
				i_q <= '0;
				j_q <= '0;
				if (!clean_q[pair_q] && sts.empty_pair) clean_q[pair_q] <= 1'b1;
			end
			if (cmd.inner_next) begin
				if (j_q == cnt_q[pb] - 1'b1) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else j_q <= j_q + 1'b1;
			end
			if (cmd.mark_clean) clean_q[pair_q] <= 1'b1;
			if (cmd.finish) gave_q <= 1'b1;
			if (cmd.add_delay) begin
				rnd_q <= rnd_q + 1'b1;
				dly_q[who] <= dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
				clean_q[clr] <= 1'b0;
			end
			if (cmd.pair_advance) pair_q <= (pair_q == 2'd2) ? 2'd0 : pair_q + 1'b1;
			if (out_taken)
				for (int k = 0; k < 3; k++) cnt_q[k] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && cnt_q[path_index] != '0 && cnt_q[path_index] < CW'(MAX_SAMPLES))
			tot_q[path_index] <= arc_length;
		else if (load_en && cnt_q[path_index] == '0)
			tot_q[path_index] <= arc_length;
		if (cmd.out_load) begin
			out0_q <= times5(dly_q[0]);
			out1_q <= times5(dly_q[1]);
			out2_q <= times5(dly_q[2]);
		end
	end

	assign delay_robot0 = out0_q;
	assign delay_robot1 = out1_q;
	assign delay_robot2 = out2_q;
	assign gave_up = gave_q;
endmodule
`default_nettype wire

@@ verif/multi_robot_wait_scheduler_core_tb.sv @@
`default_nettype none
module multi_robot_wait_scheduler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSAMP = 256;
	localparam int NROUND = 1024;
	localparam longint SAT = 64'hFFFF_FFFF;
	localparam int LIMIT = 300000000;

	typedef struct {
		logic [31:0] d0, d1, d2;
		logic        gave;
	} delays_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall;
	logic [1:0] path_index = 0;
	logic [23:0] sample_x = 0, sample_y = 0, arc_length = 0;
	logic last_sample = 0;
	logic out_valid, out_stall = 0;
	logic [31:0] delay_robot0, delay_robot1, delay_robot2;
	logic gave_up;
	logic cfg_we = 0;
	logic [1:0] cfg_index = 0;
	logic [15:0] cfg_data = 0;

	multi_robot_wait_scheduler_core uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	delays_t pending_delays[$];
	int errors = 0, cycles = 0, stall_left = 0;
	bit no_idle = 0;

	longint sx[3][NSAMP], sy[3][NSAMP], sl[3][NSAMP];
	int cnt[3];
	longint dacc[3];
	longint rad = 256, mar = 102;

	function automatic longint path_total(int p);
		return cnt[p] == 0 ? 0 : sl[p][cnt[p]-1];
	endfunction

	function automatic bit paths_meet(int a, int b);
		longint near, gap, dx, dy, dt;
		near = 4 * rad * rad;
		gap = 2 * rad + mar;
		for (int i = 0; i < cnt[a]; i++)
			for (int j = 0; j < cnt[b]; j++) begin
				dx = sx[a][i] - sx[b][j];
				dy = sy[a][i] - sy[b][j];
				dt = (sl[a][i] + dacc[a]) - (sl[b][j] + dacc[b]);
				if (dt < 0) dt = -dt;
				if (dx * dx + dy * dy <= near && dt <= gap) return 1;
			end
		return 0;
	endfunction

	function automatic bit solve_delays();
		int pa[3] = '{0, 1, 0};
		int pb[3] = '{1, 2, 2};
		int ca[3] = '{2, 0, 0};
		int cb[3] = '{1, 2, 1};
		logic [2:0] clean;
		int rounds, who, clr;
		longint w;
		w = 2 * rad + mar;
		dacc = '{0, 0, 0};
		clean = 0;
		rounds = 0;
		forever begin
			for (int p = 0; p < 3; p++)
				while (!clean[p]) begin
					if (!paths_meet(pa[p], pb[p])) begin
						clean[p] = 1;
						continue;
					end
					if (rounds >= NROUND) return 1;
					rounds++;
					if (path_total(pa[p]) < path_total(pb[p])) begin
						who = pb[p]; clr = cb[p];
					end else begin
						who = pa[p]; clr = ca[p];
					end
					dacc[who] += w;
					if (dacc[who] > SAT) dacc[who] = SAT;
					clean[clr] = 0;
				end
			if (clean == 3'b111) return 0;
		end
	endfunction

	function automatic logic [31:0] times_five(longint v);
		return v * 5 > SAT ? 32'hFFFF_FFFF : 32'(v * 5);
	endfunction

	task automatic predict_sample(logic [1:0] p, logic [23:0] x, y, len, logic ls);
		delays_t e;
		if (p == 2'd3) return;
		if (cnt[p] < NSAMP) begin
			sx[p][cnt[p]] = longint'($signed(x));
			sy[p][cnt[p]] = longint'($signed(y));
			sl[p][cnt[p]] = longint'(len);
			cnt[p]++;
		end
		if (p != 2'd2 || !ls) return;
		e.gave = solve_delays();
		e.d0 = times_five(dacc[0]);
		e.d1 = times_five(dacc[1]);
		e.d2 = times_five(dacc[2]);
		pending_delays.push_back(e);
		cnt = '{0, 0, 0};
	endtask

	task automatic send_sample(logic [1:0] p, logic [23:0] x, y, len, logic ls);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		path_index <= p;
		sample_x <= x;
		sample_y <= y;
		arc_length <= len;
		last_sample <= ls;
		do @(posedge clk); while (in_stall);
		predict_sample(p, x, y, len, ls);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_delays.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == mrws_pkg::REG_RADIUS) rad = val; else mar = val;
	endtask

	// out_stall: per-transaction random hold-off, counted while a result waits
	always @(posedge clk) begin
		int n;
		n = stall_left;
		if (out_valid && !out_stall) n = no_idle ? 0 : $urandom_range(0, 8);
		else if (out_valid && n > 0) n--;
		stall_left = n;
		out_stall <= (n > 0);
	end

	always @(posedge clk) begin
		delays_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_delays.size() == 0) begin
				$display("%0t unexpected result d0=%h d1=%h d2=%h gave=%b", $time,
					delay_robot0, delay_robot1, delay_robot2, gave_up);
				errors++;
			end else begin
				e = pending_delays.pop_front();
				if (delay_robot0 !== e.d0) begin
					$display("%0t delay_robot0 exp %h got %h", $time, e.d0, delay_robot0);
					errors++;
				end
				if (delay_robot1 !== e.d1) begin
					$display("%0t delay_robot1 exp %h got %h", $time, e.d1, delay_robot1);
					errors++;
				end
				if (delay_robot2 !== e.d2) begin
					$display("%0t delay_robot2 exp %h got %h", $time, e.d2, delay_robot2);
					errors++;
				end
				if (gave_up !== e.gave) begin
					$display("%0t gave_up exp %b got %b", $time, e.gave, gave_up);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		// extremes of coordinates and length, ignored path three
		send_sample(2'd0, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 0);
		send_sample(2'd3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1);
		send_sample(2'd1, 24'h7FFFFF, 24'h800000, 24'h000000, 1);
		send_sample(2'd2, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1);
		// all paths empty except path two
		send_sample(2'd2, 24'd0, 24'd0, 24'd0, 1);
		// tied totals, shared point; last marks on paths zero and one
		send_sample(2'd0, 24'd100, 24'd100, 24'd50, 1);
		send_sample(2'd1, 24'd100, 24'd100, 24'd50, 1);
		send_sample(2'd2, 24'd100, 24'd100, 24'd50, 1);
		// longer second robot waits
		send_sample(2'd0, 24'hFFFFF0, 24'd0, 24'd10, 0);
		send_sample(2'd1, 24'hFFFFF0, 24'd3, 24'd10, 0);
		send_sample(2'd1, 24'd500, 24'd500, 24'd900, 1);
		send_sample(2'd2, 24'hFFFFF1, 24'd1, 24'd20, 0);
		send_sample(2'd2, 24'd9000, 24'd0, 24'd300, 1);
		drain();
	endtask

	task automatic test_round_cap();
		write_reg(mrws_pkg::REG_RADIUS, 16'd0);
		write_reg(mrws_pkg::REG_MARGIN, 16'd0);
		for (int p = 0; p < 3; p++) send_sample(2'(p), 24'd5, 24'd5, 24'd10, 1);
		drain();
	endtask

	task automatic test_path_full();
		write_reg(mrws_pkg::REG_RADIUS, 16'd256);
		write_reg(mrws_pkg::REG_MARGIN, 16'd102);
		no_idle = 1;
		for (int i = 0; i <= NSAMP; i++)
			send_sample(2'd0, 24'(i * 8), 24'(i), 24'(i * 16), i == NSAMP);
		no_idle = 0;
		send_sample(2'd2, 24'd1000, 24'd100, 24'd4000, 1);
		drain();
	endtask

	task automatic random_batch();
		longint w, span;
		int n;
		bit wide;
		w = 2 * rad + mar + 1;
		span = 4 * rad + 64;
		wide = ($urandom_range(0, 9) == 0);
		for (int p = 0; p < 3; p++) begin
			n = $urandom_range(0, 6);
			if (p == 2 && n == 0) n = 1;
			for (int i = 0; i < n; i++) begin
				logic [23:0] x, y, len;
				if (wide) begin
					x = 24'($urandom); y = 24'($urandom); len = 24'($urandom);
				end else begin
					x = 24'($urandom_range(0, 2 * span) - span);
					y = 24'($urandom_range(0, 2 * span) - span);
					len = 24'($urandom_range(0, 32'(8 * w)));
				end
				if ($urandom_range(0, 9) == 0)
					send_sample(2'd3, 24'($urandom), 24'($urandom), 24'($urandom),
						1'($urandom));
				send_sample(2'(p), x, y, len,
					(p == 2) ? (i == n - 1) : logic'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic test_random(int items, logic [15:0] r, logic [15:0] m);
		int start;
		write_reg(mrws_pkg::REG_RADIUS, r);
		write_reg(mrws_pkg::REG_MARGIN, m);
		start = cycles;
		no_idle = $urandom_range(0, 3) == 0;
		for (int b = 0; b < items / 10; b++) begin
			if (b % 10 == 5) no_idle = !no_idle;
			random_batch();
		end
		no_idle = 0;
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_round_cap();
		test_path_full();
		test_random(500, 16'd256, 16'd102);
		test_random(400, 16'hFFFF, 16'hFFFF);
		test_random(400, 16'd0, 16'd500);
		test_random(170, 16'd40, 16'd0);
		drain();
		if (errors == 0 && pending_delays.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
